>>> design/fsk_tone_magnitude_discriminator_defines.svh
// ---------------------------------------------------------------------------
// FSK tone magnitude discriminator: assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef FSK_TONE_MAGNITUDE_DISCRIMINATOR_DEFINES_SVH
`define FSK_TONE_MAGNITUDE_DISCRIMINATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define FSKTMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FSKTMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FSKTMD_ASSERT(lbl, prop, msg)
`define FSKTMD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/fsktmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FSK tone magnitude discriminator package
// Widths, filter constants and the types shared by front, queue and back.
// ---------------------------------------------------------------------------
package fsktmd_pkg;

    // field widths
    localparam int SAMPLE_W   = 13;
    localparam int TONE_W     = 14;  // filtered component after divide by 64
    localparam int MAG_W      = 13;  // tone magnitude
    localparam int DIFF_W     = 14;
    localparam int RAD_W      = 26;  // sum of squares
    localparam int DIV_SHIFT  = 6;
    localparam int FILT_W     = TONE_W + DIV_SHIFT;

    // window and queue sizes
    localparam int HIST_DEPTH  = 6;
    localparam int NEW_SAMPLES = 4;
    localparam int WIN_LEN     = HIST_DEPTH + NEW_SAMPLES;
    localparam int NUM_TONES   = 4;
    localparam int TONE_IDX_W  = $clog2(NUM_TONES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // half-band taps
    localparam logic signed [FILT_W-1:0] TAP_OUTER = FILT_W'(3);
    localparam logic signed [FILT_W-1:0] TAP_INNER = FILT_W'(19);
    localparam int                       TAP_CENTER_SHIFT = 5;  // center tap 32
    localparam logic signed [FILT_W-1:0] DIV_BIAS  = FILT_W'((1 <<< DIV_SHIFT) - 1);

    // tone slots in a queue entry, high before low for each phase
    localparam logic [TONE_IDX_W-1:0] TONE_EARLY_HIGH = 2'd0;
    localparam logic [TONE_IDX_W-1:0] TONE_EARLY_LOW  = 2'd1;
    localparam logic [TONE_IDX_W-1:0] TONE_LATE_HIGH  = 2'd2;
    localparam logic [TONE_IDX_W-1:0] TONE_LATE_LOW   = 2'd3;

    typedef struct packed {
        logic signed [TONE_W-1:0] i;
        logic signed [TONE_W-1:0] q;
    } t_tone;

    typedef struct packed {
        t_tone [NUM_TONES-1:0] tones;
    } t_filt_item;

endpackage
`default_nettype wire

>>> design/fsktmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FSK tone magnitude discriminator channel interfaces
// Valid/ready channels for the sample input and the difference output.
// ---------------------------------------------------------------------------
interface fsktmd_in_if;
    import fsktmd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample0_i;
    logic signed [SAMPLE_W-1:0] sample0_q;
    logic signed [SAMPLE_W-1:0] sample1_i;
    logic signed [SAMPLE_W-1:0] sample1_q;
    logic signed [SAMPLE_W-1:0] sample2_i;
    logic signed [SAMPLE_W-1:0] sample2_q;
    logic signed [SAMPLE_W-1:0] sample3_i;
    logic signed [SAMPLE_W-1:0] sample3_q;

    modport source (
        output valid, sample0_i, sample0_q, sample1_i, sample1_q,
               sample2_i, sample2_q, sample3_i, sample3_q,
        input  ready
    );
    modport sink (
        input  valid, sample0_i, sample0_q, sample1_i, sample1_q,
               sample2_i, sample2_q, sample3_i, sample3_q,
        output ready
    );
endinterface

interface fsktmd_out_if;
    import fsktmd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIFF_W-1:0] diff_early;
    logic signed [DIFF_W-1:0] diff_late;

    modport source (output valid, diff_early, diff_late, input ready);
    modport sink   (input valid, diff_early, diff_late, output ready);
endinterface
`default_nettype wire

>>> design/fsktmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FSK discriminator front end
// Accepts sample transactions, keeps the six-sample history and forms the
// eight filtered tone components that go into the queue.
// ---------------------------------------------------------------------------
module fsktmd_front #(
    parameter int SAMPLE_BITS = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    fsktmd_in_if.sink               i_in,
    input  logic                    i_full,
    output logic                    o_push,
    output fsktmd_pkg::t_filt_item  o_push_data
);
    import fsktmd_pkg::*;

    localparam int SEXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

    logic signed [SAMPLE_W-1:0] r_hist_i [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] r_hist_q [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] w_i [WIN_LEN];
    logic signed [SAMPLE_W-1:0] w_q [WIN_LEN];
    logic signed [FILT_W-1:0]   w_ai, w_aq, w_bi, w_bq;
    logic signed [FILT_W-1:0]   w_c3i, w_c3q, w_c5i, w_c5q;
    logic                       w_accept;

    // keep only the low SAMPLE_BITS bits, sign-extended
    function automatic logic signed [SAMPLE_W-1:0] sext(input logic [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] t;
        t = signed'(raw << SEXT_SHIFT);
        return t >>> SEXT_SHIFT;
    endfunction

    function automatic logic signed [FILT_W-1:0] ext(input logic signed [SAMPLE_W-1:0] v);
        return FILT_W'(v);
    endfunction

    // divide by 64, truncating toward zero
    function automatic logic signed [TONE_W-1:0] div_trunc(input logic signed [FILT_W-1:0] x);
        logic signed [FILT_W-1:0] t;
        t = x + (x[FILT_W-1] ? DIV_BIAS : '0);
        return t[FILT_W-1:DIV_SHIFT];
    endfunction

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;

    // ten-sample window: history then the four new samples
    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            w_i[k] = r_hist_i[k];
            w_q[k] = r_hist_q[k];
        end
        w_i[6] = sext(i_in.sample0_i);
        w_q[6] = sext(i_in.sample0_q);
        w_i[7] = sext(i_in.sample1_i);
        w_q[7] = sext(i_in.sample1_q);
        w_i[8] = sext(i_in.sample2_i);
        w_q[8] = sext(i_in.sample2_q);
        w_i[9] = sext(i_in.sample3_i);
        w_q[9] = sext(i_in.sample3_q);
    end

    // symmetric tap sums for both phases
    assign w_ai = TAP_INNER * (ext(w_i[4]) - ext(w_i[2]))
                + TAP_OUTER * (ext(w_i[6]) - ext(w_i[0]));
    assign w_aq = TAP_INNER * (ext(w_q[4]) - ext(w_q[2]))
                + TAP_OUTER * (ext(w_q[6]) - ext(w_q[0]));
    assign w_bi = TAP_INNER * (ext(w_i[4]) - ext(w_i[6]))
                + TAP_OUTER * (ext(w_i[2]) - ext(w_i[8]));
    assign w_bq = TAP_INNER * (ext(w_q[4]) - ext(w_q[6]))
                + TAP_OUTER * (ext(w_q[2]) - ext(w_q[8]));

    // center taps
    assign w_c3i = ext(w_i[3]) <<< TAP_CENTER_SHIFT;
    assign w_c3q = ext(w_q[3]) <<< TAP_CENTER_SHIFT;
    assign w_c5i = ext(w_i[5]) <<< TAP_CENTER_SHIFT;
    assign w_c5q = ext(w_q[5]) <<< TAP_CENTER_SHIFT;

    // shift to +fs/4 (high) and -fs/4 (low)
    always_comb begin
        o_push_data = '0;
        o_push_data.tones[TONE_EARLY_HIGH].i = div_trunc(w_ai - w_c3q);
        o_push_data.tones[TONE_EARLY_HIGH].q = div_trunc(w_aq + w_c3i);
        o_push_data.tones[TONE_EARLY_LOW].i  = div_trunc(w_ai + w_c3q);
        o_push_data.tones[TONE_EARLY_LOW].q  = div_trunc(w_aq - w_c3i);
        o_push_data.tones[TONE_LATE_HIGH].i  = div_trunc(w_bi + w_c5q);
        o_push_data.tones[TONE_LATE_HIGH].q  = div_trunc(w_bq - w_c5i);
        o_push_data.tones[TONE_LATE_LOW].i   = div_trunc(w_bi - w_c5q);
        o_push_data.tones[TONE_LATE_LOW].q   = div_trunc(w_bq + w_c5i);
    end

    assign o_push = w_accept;

    // history keeps the newest six window samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist_i[k] <= '0;
                r_hist_q[k] <= '0;
            end
        end else if (w_accept) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist_i[k] <= w_i[k + NEW_SAMPLES];
                r_hist_q[k] <= w_q[k + NEW_SAMPLES];
            end
        end
    end

endmodule
`default_nettype wire

>>> design/fsktmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FSK discriminator entry queue
// Short show-ahead queue of filtered entries between front and back end.
// ---------------------------------------------------------------------------
module fsktmd_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  fsktmd_pkg::t_filt_item  i_push_data,
    output logic                    o_full,
    input  logic                    i_pop,
    output fsktmd_pkg::t_filt_item  o_pop_data,
    output logic                    o_empty
);
    import fsktmd_pkg::*;

    t_filt_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/fsktmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "fsk_tone_magnitude_discriminator_defines.svh"
// ---------------------------------------------------------------------------
// FSK discriminator back end
// Takes queue entries, squares each tone with one shared multiplier, runs a
// bit-serial integer square root and forms the high minus low differences.
// ---------------------------------------------------------------------------
module fsktmd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  fsktmd_pkg::t_filt_item  i_pop_data,
    output logic                    o_pop,
    fsktmd_out_if.source            o_out
);
    import fsktmd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQ_I = 5'b00010,
        ST_SQ_Q = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    localparam logic [RAD_W-1:0] ROOT_BIT_INIT = RAD_W'(1) << (2 * MAG_W - 2);

    t_state                    r_state, n_state;
    t_filt_item                r_entry;
    logic [TONE_IDX_W-1:0]     r_k;
    logic [RAD_W-1:0]          r_sq;
    logic [RAD_W-1:0]          r_rad, n_rad;
    logic [RAD_W-1:0]          r_root, n_root;
    logic [RAD_W-1:0]          r_bit;
    logic [MAG_W-1:0]          r_mag_hi;
    logic signed [DIFF_W-1:0]  r_diff_early;
    logic signed [DIFF_W-1:0]  r_diff_late;
    logic                      r_out_valid;
    logic signed [DIFF_W-1:0]  r_out_early;
    logic signed [DIFF_W-1:0]  r_out_late;

    t_tone                     w_tone;
    logic signed [TONE_W-1:0]  w_comp;
    logic signed [TONE_W-1:0]  w_neg;
    logic [MAG_W-1:0]          w_abs;
    logic [RAD_W-1:0]          w_sq;
    logic [RAD_W-1:0]          w_trial;
    logic                      w_fit;
    logic                      w_root_last;
    logic [MAG_W-1:0]          w_mag;
    logic signed [DIFF_W-1:0]  w_diff;
    logic                      w_out_free;

    // shared squarer: I component, then Q component
    assign w_tone = r_entry.tones[r_k];
    assign w_comp = (r_state == ST_SQ_I) ? w_tone.i : w_tone.q;
    assign w_neg  = -w_comp;
    assign w_abs  = w_comp[TONE_W-1] ? w_neg[MAG_W-1:0] : w_comp[MAG_W-1:0];
    assign w_sq   = RAD_W'(w_abs) * RAD_W'(w_abs);

    // one root bit per cycle
    assign w_trial     = r_root + r_bit;
    assign w_fit       = (r_rad >= w_trial);
    assign n_root      = w_fit ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign n_rad       = w_fit ? (r_rad - w_trial) : r_rad;
    assign w_root_last = r_bit[0];
    assign w_mag       = n_root[MAG_W-1:0];
    assign w_diff      = {1'b0, r_mag_hi} - {1'b0, w_mag};

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_SQ_I;
                end
            end
            ST_SQ_I: n_state = ST_SQ_Q;
            ST_SQ_Q: n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_root_last) begin
                    n_state = (r_k == TONE_LATE_LOW) ? ST_DONE : ST_SQ_I;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_k <= '0;
            end else if (r_state == ST_ROOT && w_root_last) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_entry <= i_pop_data;
                end
            end
            ST_SQ_I: r_sq <= w_sq;
            ST_SQ_Q: begin
                r_rad  <= r_sq + w_sq;
                r_root <= '0;
                r_bit  <= ROOT_BIT_INIT;
            end
            ST_ROOT: begin
                r_rad  <= n_rad;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                if (w_root_last) begin
                    if (r_k == TONE_EARLY_HIGH || r_k == TONE_LATE_HIGH) begin
                        r_mag_hi <= w_mag;
                    end else if (r_k == TONE_EARLY_LOW) begin
                        r_diff_early <= w_diff;
                    end else begin
                        r_diff_late <= w_diff;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_early <= r_diff_early;
                    r_out_late  <= r_diff_late;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.diff_early = r_out_early;
    assign o_out.diff_late  = r_out_late;

    // checks
    `FSKTMD_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !r_out_valid, "result valid after reset")
    `FSKTMD_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state == ST_DONE), "result without finished entry")
    `FSKTMD_ASSERT(a_root_bit_onehot, (r_state == ST_ROOT) |-> $onehot(r_bit), "root bit lost")
    `FSKTMD_ASSERT(a_mag_range, (r_state == ST_ROOT && w_root_last) |-> (n_root < RAD_W'(6880)), "magnitude out of range")

endmodule
`default_nettype wire

>>> design/fsk_tone_magnitude_discriminator.sv
// The back end squares each tone with a shared squarer and takes a bit-serial
// square root, one tone after another, and pops the next queue entry only
// once the current result has been passed to the output register.
// The two-entry queue lets two transactions be taken while a result waits.
// Reset (synchronous, active low) zeroes the sample history and empties the
// queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// FSK tone magnitude discriminator
// Half-band tone filters at +/-fs/4 for two symbol phases, magnitude by
// integer square root, high minus low tone difference per phase.
// ---------------------------------------------------------------------------
module fsk_tone_magnitude_discriminator #(
    parameter int SAMPLE_BITS = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsktmd_in_if.sink     i_in,
    fsktmd_out_if.source  o_out
);
    import fsktmd_pkg::*;

    t_filt_item  w_push_data;
    t_filt_item  w_pop_data;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;

    // filter front end
    fsktmd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // decoupling queue
    fsktmd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    // magnitude back end
    fsktmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FSK tone magnitude discriminator testbench
// Sends four-sample transactions through the valid/ready input channel and
// checks every early/late tone difference against an in-bench model of the
// sliding window, the two shifted half-band filters and the integer square
// root. Directed edge cases come first, then tone-burst traffic with random
// content, under random idling, output back-pressure and a full drain.
// ---------------------------------------------------------------------------
module testbench;
    import fsktmd_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_iq_sample;

    typedef t_iq_sample [NEW_SAMPLES-1:0] t_burst;

    typedef struct packed {
        logic signed [DIFF_W-1:0] early;
        logic signed [DIFF_W-1:0] late;
    } t_diff_pair;

    localparam int SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SAMPLE_W - 1));
    localparam int TAP_EDGE     = 3;
    localparam int TAP_NEAR     = 19;
    localparam int TAP_MID      = 32;
    localparam int TONE_DIV     = 64;
    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS   = 5_000_000;

    logic i_clk;
    logic i_rst_n;

    fsktmd_in_if  in_ch();
    fsktmd_out_if out_ch();

    fsk_tone_magnitude_discriminator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // model state: last six window samples, zero after reset
    int win_hist_i [HIST_DEPTH];
    int win_hist_q [HIST_DEPTH];

    t_diff_pair tone_diff_q [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_cycles;
    int sent_cnt;
    int checked_cnt;
    int error_cnt;
    int tone_seq_cnt;

    // tone generator phasor
    int tone_re;
    int tone_im;
    bit tone_up;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

    // floor of the square root by bisection
    function automatic int tone_mag(int re, int im);
        int power;
        int lo;
        int hi;
        int mid;
        power = re * re + im * im;
        lo = 0;
        hi = 1 << 13;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= power) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // window, filters, magnitudes; advances the sample history
    function automatic t_diff_pair predict_tone_diff(t_burst b);
        int wi [WIN_LEN];
        int wq [WIN_LEN];
        int ei;
        int eq;
        int li;
        int lq;
        int mag_hi;
        int mag_lo;
        t_diff_pair d;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            wi[k] = win_hist_i[k];
            wq[k] = win_hist_q[k];
        end
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            wi[HIST_DEPTH + k] = int'(b[k].re);
            wq[HIST_DEPTH + k] = int'(b[k].im);
        end

        // early phase, centered on w[3]
        ei = -TAP_EDGE * wi[0] - TAP_NEAR * wi[2] + TAP_NEAR * wi[4] + TAP_EDGE * wi[6];
        eq = -TAP_EDGE * wq[0] - TAP_NEAR * wq[2] + TAP_NEAR * wq[4] + TAP_EDGE * wq[6];
        mag_hi = tone_mag((ei - TAP_MID * wq[3]) / TONE_DIV, (eq + TAP_MID * wi[3]) / TONE_DIV);
        mag_lo = tone_mag((ei + TAP_MID * wq[3]) / TONE_DIV, (eq - TAP_MID * wi[3]) / TONE_DIV);
        d.early = DIFF_W'(mag_hi - mag_lo);

        // late phase, centered on w[5]
        li = TAP_EDGE * wi[2] + TAP_NEAR * wi[4] - TAP_NEAR * wi[6] - TAP_EDGE * wi[8];
        lq = TAP_EDGE * wq[2] + TAP_NEAR * wq[4] - TAP_NEAR * wq[6] - TAP_EDGE * wq[8];
        mag_hi = tone_mag((li + TAP_MID * wq[5]) / TONE_DIV, (lq - TAP_MID * wi[5]) / TONE_DIV);
        mag_lo = tone_mag((li - TAP_MID * wq[5]) / TONE_DIV, (lq + TAP_MID * wi[5]) / TONE_DIV);
        d.late = DIFF_W'(mag_hi - mag_lo);

        for (int k = 0; k < HIST_DEPTH; k++) begin
            win_hist_i[k] = wi[k + NEW_SAMPLES];
            win_hist_q[k] = wq[k + NEW_SAMPLES];
        end
        return d;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(int v);
        if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_burst fill_burst(int re, int im);
        t_burst b;
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            b[k].re = clip_sample(re);
            b[k].im = clip_sample(im);
        end
        return b;
    endfunction

    function automatic t_burst random_burst();
        t_burst b;
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            b[k].re = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
            b[k].im = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
        end
        return b;
    endfunction

    // full-scale corners mixed with small and random values
    function automatic t_burst corner_burst();
        t_burst b;
        int pick [2];
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            for (int c = 0; c < 2; c++) begin
                case ($urandom_range(5))
                    0: pick[c] = SAMPLE_MIN;
                    1: pick[c] = SAMPLE_MAX;
                    2: pick[c] = 0;
                    3: pick[c] = -1;
                    4: pick[c] = 1;
                    default: pick[c] = int'($urandom_range(2 * SAMPLE_MAX)) - SAMPLE_MAX;
                endcase
            end
            b[k].re = clip_sample(pick[0]);
            b[k].im = clip_sample(pick[1]);
        end
        return b;
    endfunction

    // four samples of a +/-fs/4 tone; phasor turns a quarter per sample
    function automatic t_burst tone_burst(int noise);
        t_burst b;
        int t;
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            b[k].re = clip_sample(tone_re + int'($urandom_range(2 * noise)) - noise);
            b[k].im = clip_sample(tone_im + int'($urandom_range(2 * noise)) - noise);
            t = tone_re;
            if (tone_up) begin
                tone_re = -tone_im;
                tone_im = t;
            end else begin
                tone_re = tone_im;
                tone_im = -t;
            end
        end
        return b;
    endfunction

    // one sample transaction, with an optional idle gap in front
    task automatic send_burst(input t_burst b);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample0_i <= b[0].re;
        in_ch.sample0_q <= b[0].im;
        in_ch.sample1_i <= b[1].re;
        in_ch.sample1_q <= b[1].im;
        in_ch.sample2_i <= b[2].re;
        in_ch.sample2_q <= b[2].im;
        in_ch.sample3_i <= b[3].re;
        in_ch.sample3_q <= b[3].im;
        do @(posedge i_clk); while (!in_ch.ready);
        tone_diff_q.push_back(predict_tone_diff(b));
        sent_cnt++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tone_diff_q.size() != 0);
    endtask

    // mostly FSK bursts with symbol changes, some raw noise and corners
    task automatic run_random_mix(input int n_items);
        int left;
        int seq_len;
        int noise;
        int amp;
        int kind;
        left = n_items;
        while (left > 0) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                tone_seq_cnt++;
                amp = ($urandom_range(3) == 0) ? SAMPLE_MAX : $urandom_range(1, SAMPLE_MAX);
                tone_re = int'($urandom_range(2 * amp)) - amp;
                tone_im = int'($urandom_range(2 * amp)) - amp;
                tone_up = 1'($urandom_range(1));
                noise = $urandom_range(1) ? 0 : $urandom_range(300);
                seq_len = $urandom_range(4, 24);
                for (int n = 0; n < seq_len && left > 0; n++) begin
                    if ($urandom_range(7) == 0) tone_up = ~tone_up;
                    send_burst(tone_burst(noise));
                    left--;
                end
            end else if (kind < 90) begin
                send_burst(random_burst());
                left--;
            end else begin
                send_burst(corner_burst());
                left--;
            end
        end
    endtask

    // full-scale and zero fields; the first item sees the cleared window
    task automatic test_extremes();
        t_burst b;
        send_burst(fill_burst(0, 0));
        send_burst(fill_burst(SAMPLE_MAX, SAMPLE_MAX));
        send_burst(fill_burst(SAMPLE_MIN, SAMPLE_MIN));
        send_burst(fill_burst(SAMPLE_MAX, SAMPLE_MIN));
        for (int k = 0; k < NEW_SAMPLES; k++) begin
            b[k].re = clip_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX);
            b[k].im = clip_sample((k % 2) ? SAMPLE_MAX : SAMPLE_MIN);
        end
        send_burst(b);
        send_burst(fill_burst(SAMPLE_MIN, SAMPLE_MAX));
    endtask

    // clean full-scale tones in both directions
    task automatic test_tone_directions();
        tone_re = SAMPLE_MAX;
        tone_im = 0;
        tone_up = 1'b1;
        repeat (3) send_burst(tone_burst(0));
        tone_re = 0;
        tone_im = -SAMPLE_MAX;
        tone_up = 1'b0;
        repeat (3) send_burst(tone_burst(0));
    endtask

    // small negative filter outputs must round toward zero
    task automatic test_truncation();
        t_burst b;
        b = '0;
        b[1].re = 3;
        b[1].im = -3;
        b[3].re = -5;
        b[3].im = 5;
        send_burst(b);
        send_burst(fill_burst(0, 0));
        send_burst(fill_burst(-1, 1));
        send_burst(fill_burst(1, -1));
    endtask

    // two single samples walking through the outer and inner taps of the window
    task automatic test_impulse_path();
        t_burst b;
        b = '0;
        b[0].re = SAMPLE_W'(SAMPLE_MAX);
        b[2].im = SAMPLE_W'(SAMPLE_MIN);
        send_burst(b);
        repeat (3) send_burst(fill_burst(0, 0));
    endtask

    // no idling on either side
    task automatic test_full_rate_stream(input int n_items);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random_mix(n_items);
        tx_idle_pct = IDLE_PCT;
        rx_stall_pct = IDLE_PCT;
    endtask

    task automatic test_random_with_idling(input int n_items);
        tx_idle_pct = IDLE_PCT;
        rx_stall_pct = IDLE_PCT;
        run_random_mix(n_items);
    endtask

    // receiver closed for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_hold_cycles = HOLD_CYCLES;
        run_random_mix(10);
        tx_idle_pct = IDLE_PCT;
    endtask

    // sender stops until everything is out, then resumes
    task automatic test_sender_pause();
        run_random_mix(6);
        wait_drained();
        run_random_mix(6);
    endtask

    // result checker and output ready driver
    initial begin
        t_diff_pair want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (tone_diff_q.size() == 0) begin
                    $error("unexpected result transaction: diff_early=%0d diff_late=%0d",
                           out_ch.diff_early, out_ch.diff_late);
                    error_cnt++;
                end else begin
                    want = tone_diff_q.pop_front();
                    checked_cnt++;
                    if (out_ch.diff_early !== want.early) begin
                        $error("diff_early mismatch: expected %0d, actual %0d",
                               want.early, out_ch.diff_early);
                        error_cnt++;
                    end
                    if (out_ch.diff_late !== want.late) begin
                        $error("diff_late mismatch: expected %0d, actual %0d",
                               want.late, out_ch.diff_late);
                        error_cnt++;
                    end
                end
            end
            if (rx_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample0_i <= '0;
        in_ch.sample0_q <= '0;
        in_ch.sample1_i <= '0;
        in_ch.sample1_q <= '0;
        in_ch.sample2_i <= '0;
        in_ch.sample2_q <= '0;
        in_ch.sample3_i <= '0;
        in_ch.sample3_q <= '0;
        tx_idle_pct = IDLE_PCT;
        rx_stall_pct = IDLE_PCT;
        rx_hold_cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_tone_directions();
        test_truncation();
        test_impulse_path();
        test_full_rate_stream(150);
        test_random_with_idling(580);
        test_output_backpressure();
        test_sender_pause();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sample transactions (%0d FSK tone bursts), %0d results checked",
                 sent_cnt, tone_seq_cnt, checked_cnt);
        $display("including corner values, idling on both sides and a long output hold-off");
        if (error_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/fsktmd_pkg.sv
design/fsktmd_if.sv
design/fsktmd_front.sv
design/fsktmd_fifo.sv
design/fsktmd_back.sv
design/fsk_tone_magnitude_discriminator.sv
sim/testbench.sv
